// ----- rtl/dct_block_run_length_vli_packer_macros.svh -----
// Assertion macros used by the packer RTL.
`ifndef DCT_BLOCK_RUN_LENGTH_VLI_PACKER_MACROS_SVH
`define DCT_BLOCK_RUN_LENGTH_VLI_PACKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DRLV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DRLV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/drlv_pkg.sv -----
`timescale 1ns / 1ps

package drlv_pkg;

  localparam int COEFF_WIDTH_DEF = 12;
  localparam int TOTAL_WIDTH_DEF = 24;

  localparam int BLOCK_SIZE = 64;
  localparam int POS_W      = 6;
  localparam int RUN_W      = 4;
  localparam int SIZE_W     = 4;
  localparam int LEN_W      = 5;
  localparam int WORD_W     = 32;
  localparam int ACC_W      = 64;
  localparam int PEND_W     = 6;
  localparam int VALID_W    = 3;
  localparam int STREAM_W   = 24;

  localparam logic OP_COEFF = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t LAST_POS = pos_t'(BLOCK_SIZE - 1);
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};
  localparam logic [VALID_W-1:0] FULL_BYTES = VALID_W'(WORD_W / 8);

  // Zigzag position -> raster index.
  localparam pos_t SCAN_ORDER [BLOCK_SIZE] = '{
    6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

  // Raster index -> zigzag position.
  localparam pos_t ZIGZAG_POS [BLOCK_SIZE] = '{
    6'd0,  6'd1,  6'd5,  6'd6,  6'd14, 6'd15, 6'd27, 6'd28,
    6'd2,  6'd4,  6'd7,  6'd13, 6'd16, 6'd26, 6'd29, 6'd42,
    6'd3,  6'd8,  6'd12, 6'd17, 6'd25, 6'd30, 6'd41, 6'd43,
    6'd9,  6'd11, 6'd18, 6'd24, 6'd31, 6'd40, 6'd44, 6'd53,
    6'd10, 6'd19, 6'd23, 6'd32, 6'd39, 6'd45, 6'd52, 6'd54,
    6'd20, 6'd22, 6'd33, 6'd38, 6'd46, 6'd51, 6'd55, 6'd60,
    6'd21, 6'd34, 6'd37, 6'd47, 6'd50, 6'd56, 6'd59, 6'd61,
    6'd35, 6'd36, 6'd48, 6'd49, 6'd57, 6'd58, 6'd62, 6'd63
  };

  typedef struct packed {
    logic load;
    pos_t load_addr;
    logic rd_en;
    pos_t rd_addr;
    logic step;
    logic dc;
    logic emit_end;
    logic flush;
  } cmd_t;

  typedef struct packed {
    pos_t last_pos;
    logic slot_free;
  } status_t;

endpackage

// ----- rtl/drlv_coef_if.sv -----
`timescale 1ns / 1ps

interface drlv_coef_if #(
  parameter int COEFF_WIDTH = drlv_pkg::COEFF_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [COEFF_WIDTH-1:0] coefficient;

  modport source (output valid, op, coefficient, input ready);
  modport sink (input valid, op, coefficient, output ready);
endinterface

// ----- rtl/drlv_word_if.sv -----
`timescale 1ns / 1ps

interface drlv_word_if;
  logic                            valid;
  logic                            ready;
  logic [drlv_pkg::WORD_W-1:0]     word;
  logic [drlv_pkg::VALID_W-1:0]    valid_bytes;
  logic [drlv_pkg::STREAM_W-1:0]   stream_bytes;
  logic                            last;

  modport source (output valid, word, valid_bytes, stream_bytes, last, input ready);
  modport sink (input valid, word, valid_bytes, stream_bytes, last, output ready);
endinterface

// ----- rtl/drlv_ram.sv -----
`timescale 1ns / 1ps

module drlv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = drlv_pkg::BLOCK_SIZE
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/drlv_ctrl.sv -----
`timescale 1ns / 1ps

module drlv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  input  drlv_pkg::status_t status,
  output drlv_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_CODE  = 2'd1;
  localparam logic [1:0] S_TAIL  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]     state;
  drlv_pkg::pos_t load_pos;
  drlv_pkg::pos_t cur_pos;
  logic           data_valid;

  logic           accept;
  logic           step;
  drlv_pkg::pos_t rd_pos;

  assign in_ready = (state == S_LOAD);
  assign accept   = in_valid && in_ready;
  assign step     = (state == S_CODE) && data_valid && status.slot_free;
  assign rd_pos   = data_valid ? drlv_pkg::pos_t'(cur_pos + 1'b1) : '0;

  always_comb begin
    cmd           = '0;
    cmd.load      = accept && (in_op == drlv_pkg::OP_COEFF);
    cmd.load_addr = load_pos;
    cmd.step      = step;
    cmd.dc        = (cur_pos == '0);
    cmd.rd_en     = (state == S_CODE) &&
                    (!data_valid || (step && (cur_pos != status.last_pos)));
    cmd.rd_addr   = drlv_pkg::SCAN_ORDER[rd_pos];
    cmd.emit_end  = (state == S_TAIL) && (status.last_pos != drlv_pkg::LAST_POS) &&
                    status.slot_free;
    cmd.flush     = (state == S_FLUSH) && status.slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_pos   <= '0;
      cur_pos    <= '0;
      data_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (in_op == drlv_pkg::OP_FLUSH) begin
              state <= S_FLUSH;
            end else begin
              load_pos <= load_pos + 1'b1;
              if (load_pos == drlv_pkg::LAST_POS) begin
                state      <= S_CODE;
                data_valid <= 1'b0;
              end
            end
          end
        end
        S_CODE: begin
          if (!data_valid) begin
            data_valid <= 1'b1;
            cur_pos    <= '0;
          end else if (step) begin
            if (cur_pos == status.last_pos) begin
              state      <= S_TAIL;
              data_valid <= 1'b0;
            end else begin
              cur_pos <= cur_pos + 1'b1;
            end
          end
        end
        S_TAIL: begin
          if ((status.last_pos == drlv_pkg::LAST_POS) || status.slot_free) begin
            state <= S_LOAD;
          end
        end
        S_FLUSH: begin
          if (status.slot_free) begin
            state    <= S_LOAD;
            load_pos <= '0;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ----- rtl/drlv_datapath.sv -----
`timescale 1ns / 1ps

module drlv_datapath #(
  parameter int COEFF_WIDTH = drlv_pkg::COEFF_WIDTH_DEF,
  parameter int TOTAL_WIDTH = drlv_pkg::TOTAL_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [COEFF_WIDTH-1:0]     coefficient,
  input  drlv_pkg::cmd_t                    cmd,
  output drlv_pkg::status_t                 status,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [drlv_pkg::WORD_W-1:0]       word,
  output logic [drlv_pkg::VALID_W-1:0]      valid_bytes,
  output logic [drlv_pkg::STREAM_W-1:0]     stream_bytes,
  output logic                              last
);

  localparam int VLI_W   = COEFF_WIDTH - 1;
  localparam int ENTRY_W = drlv_pkg::SIZE_W + VLI_W;
  localparam int HEAD_W  = drlv_pkg::RUN_W + drlv_pkg::SIZE_W;
  localparam int SYM_W   = HEAD_W + VLI_W;
  localparam int ACC_W   = drlv_pkg::ACC_W;
  localparam int PEND_W  = drlv_pkg::PEND_W;
  localparam int LEN_W   = drlv_pkg::LEN_W;
  localparam int WORD_W  = drlv_pkg::WORD_W;

  localparam logic [COEFF_WIDTH-1:0] MOST_NEG = {1'b1, {VLI_W{1'b0}}};

  // Load side: saturate, take the magnitude and precode size and VLI bits.
  logic                          neg;
  logic [COEFF_WIDTH-1:0]        negated;
  logic [VLI_W-1:0]              mag;
  logic [drlv_pkg::SIZE_W-1:0]   size_in;
  logic [VLI_W-1:0]              size_mask;
  logic [VLI_W-1:0]              vli_in;
  drlv_pkg::pos_t                zz_pos;

  assign neg     = coefficient[COEFF_WIDTH-1];
  assign negated = -coefficient;
  assign zz_pos  = drlv_pkg::ZIGZAG_POS[cmd.load_addr];

  always_comb begin
    if (coefficient == MOST_NEG) begin
      mag = {VLI_W{1'b1}};
    end else if (neg) begin
      mag = negated[VLI_W-1:0];
    end else begin
      mag = coefficient[VLI_W-1:0];
    end
    size_in = '0;
    for (int i = 0; i < VLI_W; i++) begin
      if (mag[i]) begin
        size_in = drlv_pkg::SIZE_W'(i + 1);
      end
    end
    size_mask = ~({VLI_W{1'b1}} << size_in);
    vli_in    = neg ? (~mag & size_mask) : mag;
  end

  logic [ENTRY_W-1:0]            rd_data;
  logic [drlv_pkg::SIZE_W-1:0]   rd_size;
  logic [VLI_W-1:0]              rd_vli;

  drlv_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (drlv_pkg::BLOCK_SIZE)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.load),
    .wr_addr (cmd.load_addr),
    .wr_data ({size_in, vli_in}),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.rd_addr),
    .rd_data (rd_data)
  );

  assign rd_size = rd_data[ENTRY_W-1 -: drlv_pkg::SIZE_W];
  assign rd_vli  = rd_data[VLI_W-1:0];

  // Coding side.
  logic [ACC_W-1:0]               acc;
  logic [PEND_W-1:0]              pending;
  logic [TOTAL_WIDTH-1:0]         total;
  logic [drlv_pkg::RUN_W-1:0]     run;
  drlv_pkg::pos_t                 last_pos;

  logic [HEAD_W-1:0]              head;
  logic [drlv_pkg::SIZE_W-1:0]    sym_size;
  logic [VLI_W-1:0]               sym_vli;
  logic [LEN_W-1:0]               sym_len;
  logic [drlv_pkg::RUN_W-1:0]     run_next;
  logic [SYM_W-1:0]               sym_val;
  logic [ACC_W-1:0]               sym_top;
  logic [ACC_W-1:0]               acc_sum;
  logic [PEND_W-1:0]              pend_sum;
  logic                           word_full;
  logic [PEND_W-1:0]              pend_round;
  logic [drlv_pkg::VALID_W-1:0]   flush_bytes;
  logic [TOTAL_WIDTH-1:0]         total_word;
  logic [TOTAL_WIDTH-1:0]         total_flush;

  always_comb begin
    head     = '0;
    sym_size = '0;
    sym_vli  = '0;
    sym_len  = '0;
    run_next = run;
    if (cmd.emit_end) begin
      sym_len = LEN_W'(HEAD_W);
    end else if (cmd.step) begin
      if (cmd.dc) begin
        head     = HEAD_W'(rd_size);
        sym_size = rd_size;
        sym_vli  = rd_vli;
        sym_len  = LEN_W'(drlv_pkg::SIZE_W) + LEN_W'(rd_size);
        run_next = '0;
      end else if (rd_size == '0) begin
        if (run == drlv_pkg::RUN_MAX) begin
          head     = {drlv_pkg::RUN_MAX, {drlv_pkg::SIZE_W{1'b0}}};
          sym_len  = LEN_W'(HEAD_W);
          run_next = '0;
        end else begin
          run_next = run + 1'b1;
        end
      end else begin
        head     = {run, rd_size};
        sym_size = rd_size;
        sym_vli  = rd_vli;
        sym_len  = LEN_W'(HEAD_W) + LEN_W'(rd_size);
        run_next = '0;
      end
    end
  end

  // Left-align the symbol, then drop it just below the bits already pending.
  assign sym_val   = (SYM_W'(head) << sym_size) | SYM_W'(sym_vli);
  assign sym_top   = {sym_val, {(ACC_W-SYM_W){1'b0}}} << (LEN_W'(SYM_W) - sym_len);
  assign acc_sum   = acc | (sym_top >> pending);
  assign pend_sum  = pending + PEND_W'(sym_len);
  assign word_full = (pend_sum >= PEND_W'(WORD_W));

  assign pend_round  = pending + PEND_W'(7);
  assign flush_bytes = pend_round[PEND_W-1 -: drlv_pkg::VALID_W];
  assign total_word  = total + TOTAL_WIDTH'(drlv_pkg::FULL_BYTES);
  assign total_flush = total + TOTAL_WIDTH'(flush_bytes);

  assign status.last_pos  = last_pos;
  assign status.slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      pending   <= '0;
      total     <= '0;
      run       <= '0;
      last_pos  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        if (cmd.load_addr == '0) begin
          last_pos <= '0;
        end else if ((size_in != '0) && (zz_pos > last_pos)) begin
          last_pos <= zz_pos;
        end
      end
      if (cmd.flush) begin
        out_valid <= 1'b1;
        acc       <= '0;
        pending   <= '0;
        total     <= '0;
        run       <= '0;
      end else if (cmd.step || cmd.emit_end) begin
        run <= run_next;
        if (word_full) begin
          out_valid <= 1'b1;
          acc       <= acc_sum << WORD_W;
          pending   <= pend_sum - PEND_W'(WORD_W);
          total     <= total_word;
        end else begin
          acc     <= acc_sum;
          pending <= pend_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush) begin
      word         <= acc[ACC_W-1 -: WORD_W];
      valid_bytes  <= flush_bytes;
      stream_bytes <= drlv_pkg::STREAM_W'(total_flush);
      last         <= 1'b1;
    end else if ((cmd.step || cmd.emit_end) && word_full) begin
      word         <= acc_sum[ACC_W-1 -: WORD_W];
      valid_bytes  <= drlv_pkg::FULL_BYTES;
      stream_bytes <= drlv_pkg::STREAM_W'(total_word);
      last         <= 1'b0;
    end
  end

endmodule

// ----- rtl/dct_block_run_length_vli_packer.sv -----
`timescale 1ns / 1ps
// Load: one coefficient beat per cycle; the 64th beat of a block starts coding.
// Coding: one zigzag position per cycle while the output slot is free, from the
// block store's registered read port after a priming read, up to the last nonzero
// position; END follows unless that is position 63. Flush: the flush state loads
// the final word once the output slot is free. Reset (rst, synchronous) clears
// control, counters and the bit accumulator; the block store is not cleared.
`include "dct_block_run_length_vli_packer_macros.svh"

module dct_block_run_length_vli_packer #(
  parameter int COEFF_WIDTH = drlv_pkg::COEFF_WIDTH_DEF,
  parameter int TOTAL_WIDTH = drlv_pkg::TOTAL_WIDTH_DEF
) (
  input logic          clk,
  input logic          rst,
  drlv_coef_if.sink    coeffs,
  drlv_word_if.source  stream
);

  // The controller sequences three phases: loading a block in raster order,
  // scanning it in zigzag order, and the flush that closes the stream. It only
  // advances a coding step when the output register can take a word, so the
  // datapath never has to hold a finished word anywhere else.
  drlv_pkg::cmd_t    cmd;
  drlv_pkg::status_t status;

  drlv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (coeffs.valid),
    .in_op    (coeffs.op),
    .in_ready (coeffs.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath precodes each coefficient into size and VLI bits as it is
  // written, tracks the last nonzero zigzag position of the block, and packs
  // at most one symbol per coding step into a left-aligned 64-bit accumulator.
  // A word leaves through the output register whenever 32 bits are pending.
  drlv_datapath #(
    .COEFF_WIDTH (COEFF_WIDTH),
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .coefficient  (coeffs.coefficient),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (stream.ready),
    .out_valid    (stream.valid),
    .word         (stream.word),
    .valid_bytes  (stream.valid_bytes),
    .stream_bytes (stream.stream_bytes),
    .last         (stream.last)
  );

  // A step that may produce a word must only run when the output slot is free.
  `DRLV_ASSERT_NOW(a_step_slot, clk, rst, (cmd.step || cmd.emit_end || cmd.flush), status.slot_free, "coding step issued while output slot is busy")

  // Loading, coding and flushing never overlap.
  `DRLV_ASSERT_NOW(a_one_cmd, clk, rst, 1'b1, $onehot0({cmd.load, cmd.step, cmd.emit_end, cmd.flush}), "more than one datapath command in a cycle")

  // A flush always presents its final beat on the next cycle.
  `DRLV_ASSERT_NEXT(a_flush_out, clk, rst, cmd.flush, (stream.valid && stream.last), "flush did not produce a final beat")

endmodule

// ----- tb/drlv_packer_checker.sv -----
`timescale 1ns / 1ps

module drlv_packer_checker (
  input  logic clk,
  input  logic rst,
  drlv_coef_if coeffs,
  drlv_word_if stream,
  output int   mismatch_count,
  output int   words_pending
);

  localparam int CW        = drlv_pkg::COEFF_WIDTH_DEF;
  localparam int COEFF_MIN = -(1 << (CW - 1));
  localparam int ZRL_RUN   = 15;
  localparam int ZRL_SIZE  = 0;
  localparam int EOB_RUN   = 0;
  localparam int EOB_SIZE  = 0;
  localparam int MAX_RUN   = 16;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  valid_bytes;
    logic [23:0] stream_bytes;
    logic        last;
  } word_beat_t;

  word_beat_t  expected_words[$];
  word_beat_t  want;
  int          zigzag_to_raster[64];
  int          block_coeffs[64];
  logic [5:0]  fill_index;
  logic [63:0] bit_buffer;
  logic [5:0]  bit_count;
  logic [23:0] byte_count;

  // Walk the anti-diagonals of the 8x8 block, alternating direction.
  initial begin
    int n;
    int r;
    n = 0;
    for (int s = 0; s < 15; s++) begin
      if (s % 2 == 0) begin
        for (r = (s < 8) ? s : 7; r >= 0 && s - r < 8; r--) begin
          zigzag_to_raster[n] = r * 8 + (s - r);
          n++;
        end
      end else begin
        for (r = (s < 8) ? 0 : s - 7; r < 8 && s - r >= 0; r++) begin
          zigzag_to_raster[n] = r * 8 + (s - r);
          n++;
        end
      end
    end
    mismatch_count = 0;
    words_pending  = 0;
  end

  function automatic void push_word(logic [31:0] w, logic [2:0] nbytes, logic is_last);
    expected_words.push_back('{word: w, valid_bytes: nbytes, stream_bytes: byte_count,
                               last: is_last});
  endfunction

  function automatic void append_bits(int n, int unsigned bits);
    logic [63:0] field;
    logic [31:0] w;
    field      = 64'(bits) & ((64'd1 << n) - 64'd1);
    bit_buffer = (bit_buffer << n) | field;
    bit_count  = 6'(bit_count + n);
    if (bit_count >= 6'd32) begin
      w          = 32'(bit_buffer >> (bit_count - 32));
      bit_count  = bit_count - 6'd32;
      bit_buffer = bit_buffer & ((64'd1 << bit_count) - 64'd1);
      byte_count = byte_count + 24'd4;
      push_word(w, 3'd4, 1'b0);
    end
  endfunction

  function automatic void append_value(int run, int x, bit with_run);
    int unsigned mag;
    int unsigned vli;
    int          size;
    mag  = (x < 0) ? -x : x;
    size = 0;
    while (size < 16 && (mag >> size) != 0) size++;
    vli = (x < 0) ? (~mag & ((1 << size) - 1)) : mag;
    if (with_run) append_bits(4, run);
    append_bits(4, size);
    append_bits(size, vli);
  endfunction

  function automatic void code_zigzag_block();
    int last_nz;
    int pos;
    int run;
    append_value(0, block_coeffs[0], 1'b0);
    last_nz = 63;
    while (last_nz > 0 && block_coeffs[zigzag_to_raster[last_nz]] == 0) last_nz--;
    pos = 1;
    while (pos <= last_nz) begin
      run = 0;
      while (run < MAX_RUN && block_coeffs[zigzag_to_raster[pos]] == 0) begin
        run++;
        pos++;
      end
      if (run == MAX_RUN) begin
        append_bits(4, ZRL_RUN);
        append_bits(4, ZRL_SIZE);
      end else begin
        append_value(run, block_coeffs[zigzag_to_raster[pos]], 1'b1);
        pos++;
      end
    end
    // The end-of-block code is left out when the last zigzag position is used.
    if (last_nz < 63) begin
      append_bits(4, EOB_RUN);
      append_bits(4, EOB_SIZE);
    end
  endfunction

  function automatic void take_coefficient(logic signed [CW-1:0] c);
    int v;
    v = c;
    if (v == COEFF_MIN) v = COEFF_MIN + 1;
    block_coeffs[fill_index] = v;
    fill_index = fill_index + 6'd1;
    if (fill_index == 6'd0) code_zigzag_block();
  endfunction

  function automatic void take_flush();
    int          nbytes;
    logic [31:0] w;
    nbytes     = (bit_count + 7) / 8;
    w          = 32'(bit_buffer << (32 - bit_count));
    byte_count = byte_count + 24'(nbytes);
    push_word(w, 3'(nbytes), 1'b1);
    fill_index = '0;
    bit_buffer = '0;
    bit_count  = '0;
    byte_count = '0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fill_index = '0;
      bit_buffer = '0;
      bit_count  = '0;
      byte_count = '0;
      expected_words.delete();
    end else begin
      if (stream.valid && stream.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected output word %h (valid_bytes %0d, last %b)",
                 stream.word, stream.valid_bytes, stream.last);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          if (stream.word !== want.word) begin
            $error("word: expected %h, got %h", want.word, stream.word);
            mismatch_count++;
          end
          if (stream.valid_bytes !== want.valid_bytes) begin
            $error("valid_bytes: expected %0d, got %0d", want.valid_bytes, stream.valid_bytes);
            mismatch_count++;
          end
          if (stream.stream_bytes !== want.stream_bytes) begin
            $error("stream_bytes: expected %0d, got %0d",
                   want.stream_bytes, stream.stream_bytes);
            mismatch_count++;
          end
          if (stream.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, stream.last);
            mismatch_count++;
          end
        end
      end
      if (coeffs.valid && coeffs.ready) begin
        if (coeffs.op == drlv_pkg::OP_FLUSH) take_flush();
        else take_coefficient(coeffs.coefficient);
      end
    end
    words_pending = expected_words.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int CW           = drlv_pkg::COEFF_WIDTH_DEF;
  // At least 309 random beats on top of the 11-beat directed opening.
  localparam int TOTAL_ITEMS  = 320;
  // Long output hold-off used to back the packer up into its input.
  localparam int HOLD_CYCLES  = 400;
  // The longest legal quiet period is the hold-off; allow several times that.
  localparam int STALL_LIMIT  = 3000;
  // Settling time after the last word, well beyond the flush latency.
  localparam int DRAIN_CYCLES = 20;

  // Shapes of generated blocks: each one stresses a different part of the coder.
  typedef enum int {
    KIND_SPARSE,
    KIND_DENSE,
    KIND_RUNS,
    KIND_TAIL,
    KIND_ZERO
  } block_kind_t;

  logic clk;
  logic rst = 1'b1;
  logic steady = 1'b0;
  logic hold_go = 1'b0;
  int   mismatch_count;
  int   words_pending;
  int   items_sent = 0;
  int   stall_cycles = 0;

  drlv_coef_if coeffs ();
  drlv_word_if stream ();

  dct_block_run_length_vli_packer uut (
    .clk    (clk),
    .rst    (rst),
    .coeffs (coeffs),
    .stream (stream)
  );

  drlv_packer_checker stream_check (
    .clk            (clk),
    .rst            (rst),
    .coeffs         (coeffs),
    .stream         (stream),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every packer input starts at a known value before the first edge.
  initial begin
    coeffs.valid       = 1'b0;
    coeffs.op          = drlv_pkg::OP_COEFF;
    coeffs.coefficient = '0;
    stream.ready       = 1'b0;
  end

  // Output side. Ready changes only at falling edges. Most of the time it drops
  // at random with a probability of 14 percent; during the steady stretch it stays
  // high, and when the stimulus asks for it, ready is held low for a long counted
  // stretch so the packer's output and then its input back up.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        stream.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        stream.ready <= steady || ($urandom_range(0, 99) >= 14);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a beat. A hang ends
  // the run with a failure.
  initial begin
    wait (!rst);
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((coeffs.valid && coeffs.ready) || (stream.valid && stream.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("FAIL dct_block_run_length_vli_packer");
    $finish;
  end

  // Offers one beat, starting and ending at a falling edge. Random idle cycles
  // come first, then the beat is held until a rising edge sees ready high.
  task automatic send_beat(logic op, logic [CW-1:0] c);
    while (!steady && $urandom_range(0, 99) < 14) begin
      coeffs.valid <= 1'b0;
      @(negedge clk);
    end
    coeffs.valid       <= 1'b1;
    coeffs.op          <= op;
    coeffs.coefficient <= c;
    @(posedge clk);
    while (!coeffs.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // The coefficient field carries random noise on a flush; the packer ignores it.
  task automatic send_flush();
    send_beat(drlv_pkg::OP_FLUSH, CW'($urandom()));
  endtask

  // A nonzero coefficient whose magnitude category lies between lo and hi.
  function automatic logic [CW-1:0] rand_coeff(int lo, int hi);
    int size;
    int mag;
    size = $urandom_range(hi, lo);
    mag  = $urandom_range((1 << size) - 1, 1 << (size - 1));
    return $urandom_range(0, 1) ? CW'(-mag) : CW'(mag);
  endfunction

  // Sends one full 64-coefficient block in raster order.
  task automatic send_block(block_kind_t kind);
    int            spot_a;
    int            spot_b;
    int            spot_c;
    logic [CW-1:0] c;
    spot_a = $urandom_range(1, 63);
    spot_b = $urandom_range(1, 63);
    spot_c = $urandom_range(1, 63);
    for (int i = 0; i < 64; i++) begin
      case (kind)
        KIND_SPARSE: begin
          // Energy concentrated at low frequencies, as after real quantization.
          if (i == 0) c = rand_coeff(1, 11);
          else c = ($urandom_range(0, 63) >= i + 16) ? rand_coeff(1, 6) : '0;
        end
        KIND_DENSE: begin
          // Every coefficient large (category 9 to 11), so every symbol is long.
          c = rand_coeff(9, 11);
        end
        KIND_RUNS: begin
          // A few isolated values leave long zero runs that need ZRL codes.
          if (i == 0) c = $urandom_range(0, 1) ? rand_coeff(1, 11) : '0;
          else c = (i == spot_a || i == spot_b || i == spot_c) ? rand_coeff(1, 11) : '0;
        end
        KIND_TAIL: begin
          // Raw random bit patterns, which may include the most negative code, with
          // the final zigzag position nonzero so no end-of-block code follows.
          if (i == 63) c = rand_coeff(1, 11);
          else c = ($urandom_range(0, 3) == 0) ? '0 : CW'($urandom());
        end
        default: begin
          c = '0;
        end
      endcase
      send_beat(drlv_pkg::OP_COEFF, c);
    end
  endtask

  initial begin
    block_kind_t kind;
    int          block_index;
    int          cut_len;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening. A flush straight out of reset has nothing pending and
    // must give an empty last word.
    send_flush();
    // Field extremes, including the most negative code that gets saturated,
    // loaded into a block that a flush then drops after eight beats.
    send_beat(drlv_pkg::OP_COEFF, CW'(2047));
    send_beat(drlv_pkg::OP_COEFF, CW'(-2047));
    send_beat(drlv_pkg::OP_COEFF, CW'(-2048));
    send_beat(drlv_pkg::OP_COEFF, CW'(1));
    send_beat(drlv_pkg::OP_COEFF, CW'(-1));
    send_beat(drlv_pkg::OP_COEFF, CW'(0));
    send_beat(drlv_pkg::OP_COEFF, CW'(1024));
    send_beat(drlv_pkg::OP_COEFF, CW'(-1024));
    send_flush();
    // Back-to-back flushes restart an empty stream twice.
    send_flush();

    // Random part: mostly complete blocks with random content. The first five
    // blocks visit every block shape once; after that shapes are random.
    // Between blocks a flush or a truncated block may be thrown in.
    block_index = 0;
    while (items_sent < TOTAL_ITEMS) begin
      kind = (block_index < 5) ? block_kind_t'(block_index)
                               : block_kind_t'($urandom_range(0, 4));
      // The dense block runs into a long output hold-off while the sender
      // keeps pushing, so the packer fills up and stalls its input.
      if (block_index == 1) hold_go = 1'b1;
      // One block goes through with neither side ever idling.
      steady = (block_index == 2);
      send_block(kind);
      steady = 1'b0;
      // Once, the sender waits for every outstanding word before going on.
      if (block_index == 3) begin
        coeffs.valid <= 1'b0;
        do @(negedge clk); while (words_pending != 0);
      end
      if ($urandom_range(0, 3) == 0) begin
        cut_len = $urandom_range(1, 20);
        for (int i = 0; i < cut_len; i++)
          send_beat(drlv_pkg::OP_COEFF, rand_coeff(1, 11));
        send_flush();
      end else if ($urandom_range(0, 2) == 0) begin
        send_flush();
      end
      block_index++;
    end
    // Close the stream so the partial word and byte total come out.
    send_flush();
    coeffs.valid <= 1'b0;

    while (words_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && words_pending == 0) begin
      $display("PASS dct_block_run_length_vli_packer");
    end else begin
      $display("FAIL dct_block_run_length_vli_packer");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/drlv_pkg.sv
rtl/drlv_coef_if.sv
rtl/drlv_word_if.sv
rtl/drlv_ram.sv
rtl/drlv_ctrl.sv
rtl/drlv_datapath.sv
rtl/dct_block_run_length_vli_packer.sv
tb/drlv_packer_checker.sv
tb/testbench.sv
